[hw/rtl/fifo_tlb_hit_counter_defines.svh]
// ---------------------------------------------------------------------------
// fifo tlb hit counter assertion macros
// shared check macros for the tlb rtl
// ---------------------------------------------------------------------------
`ifndef FIFO_TLB_HIT_COUNTER_DEFINES_SVH
`define FIFO_TLB_HIT_COUNTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FTLB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ftlb check failed");

// next-cycle implication, disabled during reset
`define FTLB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ftlb check failed");

`endif

[hw/rtl/ftlb_pkg.sv]
// ---------------------------------------------------------------------------
// ftlb package
// shared types and constants of the fifo replacement tlb
// ---------------------------------------------------------------------------
package ftlb_pkg;

	localparam int CNT_BITS  = 32;
	localparam int CFG_BITS  = 5;
	localparam int SLOT_BITS = 4;
	localparam int PAGE_BITS = 32;

	localparam logic [CNT_BITS-1:0] CNT_MAX   = '1;
	localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

	// lookup probe control travelling down the cell row
	typedef struct packed {
		logic active;
		logic found;
	} probe_t;

endpackage

[hw/rtl/fifo_tlb_hit_counter.sv]
// ---------------------------------------------------------------------------
// fifo tlb hit counter
// fully associative tlb with round-robin fifo replacement and saturating
// hit / miss counters, built as a row of compare cells
// ---------------------------------------------------------------------------
//
// channel   ports                                   transfer when
// -------   -------------------------------------   --------------------
// lookup    start, busy, page_key                   start && !busy
// result    done, hit, slot, hit_total, miss_total  done (no stall)
// config    cfg_wr_en, cfg_wr_data                  cfg_wr_en
//
// a lookup walks the cell row one cell per cycle, and no new lookup is
// taken until the last one has left the row and busy has dropped; the
// length of the cell row sets how long each item holds the block
// the result strobe done is registered from the probe leaving the last
// cell, so the result follows the lookup through every cell register
// busy is high from the lookup edge until the probe leaves the row
// reset clears valid bits, fifo pointers, counters and sets the slot count
// to ENTRIES and the config register to 16; stored keys are not reset
// the result side cannot stall, so a result is shown for one cycle only
//
`include "fifo_tlb_hit_counter_defines.svh"

module fifo_tlb_hit_counter import ftlb_pkg::*; #(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_wr_en,
	input  logic [CFG_BITS-1:0]  cfg_wr_data,
	// lookup
	input  logic                 start,
	output logic                 busy,
	input  logic [PAGE_BITS-1:0] page_key,
	// result
	output logic                 done,
	output logic                 hit,
	output logic [SLOT_BITS-1:0] slot,
	output logic [CNT_BITS-1:0]  hit_total,
	output logic [CNT_BITS-1:0]  miss_total
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [CNT_W-1:0] N_MAX = CNT_W'(ENTRIES);

	// config register and clamped slot count
	logic [CFG_BITS-1:0] cfg_q;
	logic [8:0]          cfg_ext;
	logic [CNT_W-1:0]    n_cfg;
	logic [CNT_W-1:0]    n_q;

	// fifo bookkeeping
	logic [CNT_W-1:0] filled_q;
	logic [IDX_W-1:0] oldest_q;
	logic [CNT_W-1:0] oldest_ext;
	logic [IDX_W-1:0] victim;
	logic [CNT_W-1:0] victim_inc;

	// counters and result registers
	logic [CNT_BITS-1:0]  hit_cnt_q;
	logic [CNT_BITS-1:0]  miss_cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic                 hit_q;
	logic [SLOT_BITS-1:0] slot_q;

	// lookup key, masked to the key width
	logic [63:0]         page_ext;
	logic [KEY_BITS-1:0] key_in;

	// cell row links, index 0 is the row input
	probe_t              chain_p   [ENTRIES+1];
	logic [KEY_BITS-1:0] chain_key [ENTRIES+1];
	logic [IDX_W-1:0]    chain_slot[ENTRIES+1];
	logic [ENTRIES-1:0]  act_vec;

	// row exit and table update
	probe_t              row_out;
	logic                row_hit;
	logic                row_miss;
	logic                fill;
	logic [IDX_W-1:0]    res_idx;
	logic [7:0]          res_ext;
	logic                wr_en;

	logic accept;

	assign accept   = start && !busy_q;
	assign page_ext = 64'(page_key);
	assign key_in   = page_ext[KEY_BITS-1:0];

	// clamp the slot count into 1..ENTRIES
	assign cfg_ext = 9'(cfg_q);
	always_comb begin
		if (cfg_ext == 9'd0) begin
			n_cfg = CNT_W'(1);
		end else if (cfg_ext > 9'(ENTRIES)) begin
			n_cfg = N_MAX;
		end else begin
			n_cfg = cfg_ext[CNT_W-1:0];
		end
	end

	// probe enters the first cell on the lookup transfer
	assign chain_p[0].active = accept;
	assign chain_p[0].found  = 1'b0;
	assign chain_key[0]      = key_in;
	assign chain_slot[0]     = '0;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		ftlb_cell #(
			.IDX_W    (IDX_W),
			.CNT_W    (CNT_W),
			.KEY_BITS (KEY_BITS),
			.CELL_IDX (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.n_slots   (n_q),
			.in_probe  (chain_p[g]),
			.in_key    (chain_key[g]),
			.in_slot   (chain_slot[g]),
			.out_probe (chain_p[g+1]),
			.out_key   (chain_key[g+1]),
			.out_slot  (chain_slot[g+1]),
			.wr_en     (wr_en),
			.wr_idx    (res_idx),
			.wr_key    (chain_key[ENTRIES])
		);
		assign act_vec[g] = chain_p[g+1].active;
	end

	assign row_out  = chain_p[ENTRIES];
	assign row_hit  = row_out.active && row_out.found;
	assign row_miss = row_out.active && !row_out.found;

	// miss placement: fill in order, then round-robin over the oldest slot
	assign fill       = filled_q < n_q;
	assign oldest_ext = CNT_W'(oldest_q);
	assign victim     = (oldest_ext < n_q) ? oldest_q : '0;
	assign victim_inc = CNT_W'(victim) + CNT_W'(1);

	always_comb begin
		if (row_out.found) begin
			res_idx = chain_slot[ENTRIES];
		end else if (fill) begin
			res_idx = filled_q[IDX_W-1:0];
		end else begin
			res_idx = victim;
		end
	end

	assign wr_en   = row_miss;
	assign res_ext = 8'(res_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q      <= CFG_RESET;
			n_q        <= N_MAX;
			filled_q   <= '0;
			oldest_q   <= '0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			if (accept) begin
				n_q    <= n_cfg;
				busy_q <= 1'b1;
			end
			done_q <= row_out.active;
			if (row_out.active) begin
				busy_q <= 1'b0;
			end
			if (row_hit && (hit_cnt_q != CNT_MAX)) begin
				hit_cnt_q <= hit_cnt_q + CNT_BITS'(1);
			end
			if (row_miss) begin
				if (miss_cnt_q != CNT_MAX) begin
					miss_cnt_q <= miss_cnt_q + CNT_BITS'(1);
				end
				if (fill) begin
					filled_q <= filled_q + CNT_W'(1);
				end else begin
					oldest_q <= (victim_inc >= n_q) ? '0 : victim_inc[IDX_W-1:0];
				end
			end
		end
	end

	// result payload, captured as the probe leaves the row
	always_ff @(posedge clk) begin
		if (row_out.active) begin
			hit_q  <= row_out.found;
			slot_q <= res_ext[SLOT_BITS-1:0];
		end
	end

	assign busy       = busy_q;
	assign done       = done_q;
	assign hit        = hit_q;
	assign slot       = slot_q;
	assign hit_total  = hit_cnt_q;
	assign miss_total = miss_cnt_q;

	// at most one lookup in the cell row
	`FTLB_ASSERT_IMPLY(a_one_probe, clk, arst_n, 1'b1, $onehot0(act_vec))
	// a lookup transfer holds the block busy
	`FTLB_ASSERT_NEXT(a_busy_on_start, clk, arst_n, accept, busy_q)
	// a probe leaving the row yields a result strobe next cycle
	`FTLB_ASSERT_NEXT(a_exit_done, clk, arst_n, row_out.active, done_q && !busy_q)
	// a reported miss implies a nonzero miss count
	`FTLB_ASSERT_IMPLY(a_miss_count, clk, arst_n, done_q && !hit_q, miss_cnt_q != '0)
	// probes only travel while busy
	`FTLB_ASSERT_IMPLY(a_probe_busy, clk, arst_n, act_vec != '0, busy_q)

endmodule

[hw/rtl/ftlb_cell.sv]
// ---------------------------------------------------------------------------
// ftlb cell
// one tlb slot: holds a key, compares the passing probe, forwards it
// ---------------------------------------------------------------------------
module ftlb_cell import ftlb_pkg::*; #(
	parameter int IDX_W    = 4,
	parameter int CNT_W    = 5,
	parameter int KEY_BITS = 32,
	parameter int CELL_IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [CNT_W-1:0]    n_slots,
	input  probe_t              in_probe,
	input  logic [KEY_BITS-1:0] in_key,
	input  logic [IDX_W-1:0]    in_slot,
	output probe_t              out_probe,
	output logic [KEY_BITS-1:0] out_key,
	output logic [IDX_W-1:0]    out_slot,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_idx,
	input  logic [KEY_BITS-1:0] wr_key
);

	localparam logic [IDX_W-1:0] MY_SLOT = IDX_W'(CELL_IDX);
	localparam logic [CNT_W-1:0] MY_POS  = CNT_W'(CELL_IDX);

	logic [KEY_BITS-1:0] key_q;
	logic                valid_q;
	probe_t              probe_q;
	logic [KEY_BITS-1:0] pkey_q;
	logic [IDX_W-1:0]    pslot_q;
	logic                match;

	// first match wins, later cells see found set
	assign match = in_probe.active && !in_probe.found && valid_q
		&& (key_q == in_key) && (MY_POS < n_slots);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
			valid_q <= 1'b0;
		end else begin
			probe_q.active <= in_probe.active;
			probe_q.found  <= in_probe.found | match;
			if (wr_en && (wr_idx == MY_SLOT)) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		pkey_q  <= in_key;
		pslot_q <= match ? MY_SLOT : in_slot;
		if (wr_en && (wr_idx == MY_SLOT)) begin
			key_q <= wr_key;
		end
	end

	assign out_probe = probe_q;
	assign out_key   = pkey_q;
	assign out_slot  = pslot_q;

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// fifo tlb hit counter testbench
// drives page lookups through the start / busy handshake, predicts each
// result with a local copy of the tlb and its counters, and checks every
// result strobe field by field across several slot-count settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import ftlb_pkg::*;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int POOL_SIZE  = 24;
	localparam int PHASES     = 16;
	localparam int PHASE_LEN  = 75;
	// cycles with no transfer on either side before the run is declared hung;
	// the limit lies well above one lookup, the longest sender gap and the
	// idle stretch around a register write
	localparam int HANG_LIMIT = 2000;

	// one predicted result of a lookup
	typedef struct packed {
		logic                 hit;
		logic [SLOT_BITS-1:0] slot;
		logic [CNT_BITS-1:0]  hit_total;
		logic [CNT_BITS-1:0]  miss_total;
	} lookup_result_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_wr_en   = 1'b0;
	logic [CFG_BITS-1:0]  cfg_wr_data = '0;
	logic                 start       = 1'b0;
	logic                 busy;
	logic [PAGE_BITS-1:0] page_key    = '0;
	logic                 done;
	logic                 hit;
	logic [SLOT_BITS-1:0] slot;
	logic [CNT_BITS-1:0]  hit_total;
	logic [CNT_BITS-1:0]  miss_total;

	fifo_tlb_hit_counter #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.start       (start),
		.busy        (busy),
		.page_key    (page_key),
		.done        (done),
		.hit         (hit),
		.slot        (slot),
		.hit_total   (hit_total),
		.miss_total  (miss_total)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// shadow tlb: keys, valid bits, fifo pointers, counters and slot count
	// ------------------------------------------------------------------------
	logic [KEY_BITS-1:0] shadow_key   [ENTRIES];
	logic                shadow_valid [ENTRIES];
	logic [3:0]          victim_ptr   = '0;
	logic [4:0]          fill_count   = '0;
	logic [CNT_BITS-1:0] hit_count    = '0;
	logic [CNT_BITS-1:0] miss_count   = '0;
	logic [CFG_BITS-1:0] slots_cfg    = CFG_RESET;

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			shadow_key[i]   = '0;
			shadow_valid[i] = 1'b0;
		end
	end

	// look one key up in the shadow tlb and update it the way the block must
	function automatic lookup_result_t tlb_lookup(logic [PAGE_BITS-1:0] key);
		lookup_result_t res;
		int             n;
		int             idx;
		logic           found;
		n     = int'(slots_cfg);
		found = 1'b0;
		idx   = 0;
		// a zero count behaves as one slot, anything past the build as all
		if (n < 1)
			n = 1;
		if (n > ENTRIES)
			n = ENTRIES;
		// lowest matching valid slot below the current count wins
		for (int i = 0; i < n; i++) begin
			if (!found && shadow_valid[i] && shadow_key[i] == key[KEY_BITS-1:0]) begin
				found = 1'b1;
				idx   = i;
			end
		end
		if (found) begin
			if (hit_count != CNT_MAX)
				hit_count = hit_count + 1'b1;
		end else begin
			if (miss_count != CNT_MAX)
				miss_count = miss_count + 1'b1;
			if (int'(fill_count) < n) begin
				// still filling in order from slot 0
				idx        = int'(fill_count);
				fill_count = fill_count + 1'b1;
			end else begin
				// round-robin eviction; a pointer left past a shrunk count restarts at 0
				idx        = (int'(victim_ptr) < n) ? int'(victim_ptr) : 0;
				victim_ptr = (idx + 1 >= n) ? 4'd0 : 4'(idx + 1);
			end
			shadow_key[idx]   = key[KEY_BITS-1:0];
			shadow_valid[idx] = 1'b1;
		end
		res.hit        = found;
		res.slot       = SLOT_BITS'(idx);
		res.hit_total  = hit_count;
		res.miss_total = miss_count;
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// driver: pulls page keys from the pending queue, idles between transfers
	// ------------------------------------------------------------------------
	logic [PAGE_BITS-1:0] pending_keys[$];
	lookup_result_t       pending_results[$];
	int                   gap_left    = 0;
	logic                 no_idle     = 1'b0;
	int                   lookups_in  = 0;
	int                   results_out = 0;
	int                   hits_seen   = 0;
	int                   mismatches  = 0;
	logic                 lookup_xfer;

	assign lookup_xfer = start && !busy;

	// mostly back-to-back or short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			page_key <= '0;
			gap_left  = 0;
		end else begin
			// shadow register follows every write the block sees
			if (cfg_wr_en)
				slots_cfg = cfg_wr_data;
			if (lookup_xfer) begin
				pending_results.push_back(tlb_lookup(page_key));
				lookups_in++;
				gap_left = pick_gap();
			end
			// start is assigned once per edge so a held request never dips
			if (start && busy) begin
				start <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_keys.size() != 0) begin
				start    <= 1'b1;
				page_key <= pending_keys.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: each done strobe is one result transfer, checked against the
	// oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		lookup_result_t exp_res;
		if (arst_n && done) begin
			results_out++;
			if (pending_results.size() == 0) begin
				$error("result with no lookup outstanding: hit %0d slot %0d", hit, slot);
				mismatches++;
			end else begin
				exp_res = pending_results.pop_front();
				if (exp_res.hit)
					hits_seen++;
				if (hit !== exp_res.hit) begin
					$error("hit mismatch: expected %0d, got %0d", exp_res.hit, hit);
					mismatches++;
				end
				if (slot !== exp_res.slot) begin
					$error("slot mismatch: expected %0d, got %0d", exp_res.slot, slot);
					mismatches++;
				end
				if (hit_total !== exp_res.hit_total) begin
					$error("hit_total mismatch: expected %0d, got %0d",
						exp_res.hit_total, hit_total);
					mismatches++;
				end
				if (miss_total !== exp_res.miss_total) begin
					$error("miss_total mismatch: expected %0d, got %0d",
						exp_res.miss_total, miss_total);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: cycles with neither a lookup nor a result transfer
	// ------------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (lookup_xfer || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	logic [PAGE_BITS-1:0] key_pool[POOL_SIZE];
	int                   cfg_writes = 0;

	// block until every queued lookup is out and every result is back; this
	// is also where the sender holds off for the whole pipeline to drain
	task automatic drain();
		do
			@(negedge clk);
		while (pending_keys.size() != 0 || pending_results.size() != 0 || start || busy);
	endtask

	// register writes only land on an idle block, after a lookup's latency
	task automatic write_slot_count(logic [CFG_BITS-1:0] value);
		drain();
		repeat (ENTRIES + 4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= CFG_BITS'($urandom);
		cfg_writes++;
	endtask

	// keys mostly reuse a working set a bit larger than the live slot count,
	// so hits, fills and evictions all happen; the rest are fresh keys
	task automatic queue_random_phase(logic [CFG_BITS-1:0] value);
		int n;
		int span;
		n = int'(value);
		if (n < 1)
			n = 1;
		if (n > ENTRIES)
			n = ENTRIES;
		span = n + $urandom_range(0, 4);
		if (span > POOL_SIZE)
			span = POOL_SIZE;
		// refresh part of the pool; survivors keep stale entries reachable
		repeat (3)
			key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
		no_idle = ($urandom_range(0, 3) == 0);
		@(negedge clk);
		for (int i = 0; i < PHASE_LEN; i++) begin
			if ($urandom_range(0, 99) < 85)
				pending_keys.push_back(key_pool[$urandom_range(0, span - 1)]);
			else
				pending_keys.push_back($urandom);
		end
	endtask

	initial begin
		logic [CFG_BITS-1:0] cfg_plan[PHASES];
		// register extremes and the out-of-range counts first, then random
		cfg_plan[0] = 5'd1;
		cfg_plan[1] = 5'd0;
		cfg_plan[2] = 5'd16;
		cfg_plan[3] = 5'd31;
		cfg_plan[4] = 5'd3;
		cfg_plan[5] = 5'd17;
		cfg_plan[6] = 5'd2;
		cfg_plan[7] = 5'd12;
		for (int i = 8; i < PHASES; i++)
			cfg_plan[i] = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at the reset count of 16 slots: extreme keys, hits on
		// them, a full fill, fifo eviction of the oldest slots, and a re-miss
		// on an evicted key
		@(negedge clk);
		pending_keys.push_back('0);
		pending_keys.push_back('1);
		pending_keys.push_back('0);
		pending_keys.push_back('1);
		for (int k = 0; k < 14; k++)
			pending_keys.push_back(PAGE_BITS'(1) << k);
		pending_keys.push_back(32'hAAAA_AAAA);
		pending_keys.push_back(32'h5555_5555);
		pending_keys.push_back('0);
		pending_keys.push_back(32'h0000_0002);

		// random phases, each behind a register write on a drained block
		for (int p = 0; p < PHASES; p++) begin
			write_slot_count(cfg_plan[p]);
			queue_random_phase(cfg_plan[p]);
		end

		drain();
		repeat (ENTRIES + 4) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d lookups never produced a result", pending_results.size());
			mismatches++;
		end

		$display("run: %0d lookups, %0d results (%0d hits), %0d slot-count writes",
			lookups_in, results_out, hits_seen, cfg_writes);
		$display("counts covered 0, 1, 16, 31 and random, with shrink and regrow mid-run");
		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
